// ----- rtl/lz3_command_decompressor_assert.svh -----
// Assertion macros shared by the LZ3 decompressor RTL.
// Depends on nothing; included by modules that carry checks.
`ifndef LZ3_COMMAND_DECOMPRESSOR_ASSERT_SVH
`define LZ3_COMMAND_DECOMPRESSOR_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define LZ3_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define LZ3_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/lz3_pkg.sv -----
// Package for the LZ3 decompressor: phase codes, command codes and the
// controller-to-datapath command struct. Depends on nothing.
`default_nettype none
package lz3_pkg;
    localparam logic [2:0] PH_HEADER  = 3'd0;
    localparam logic [2:0] PH_LONGLEN = 3'd1;
    localparam logic [2:0] PH_OFF1    = 3'd2;
    localparam logic [2:0] PH_OFF2    = 3'd3;
    localparam logic [2:0] PH_ITER    = 3'd4;
    localparam logic [2:0] PH_ALT1    = 3'd5;
    localparam logic [2:0] PH_ALT2    = 3'd6;
    localparam logic [2:0] PH_LIT     = 3'd7;

    localparam logic [2:0] CMD_LITERAL = 3'd0;
    localparam logic [2:0] CMD_ITERATE = 3'd1;
    localparam logic [2:0] CMD_ALTERN  = 3'd2;
    localparam logic [2:0] CMD_ZERO    = 3'd3;
    localparam logic [2:0] CMD_FLIP    = 3'd5;
    localparam logic [2:0] CMD_REVERSE = 3'd6;
    // Header command field that selects the long form with a 10-bit length.
    localparam logic [2:0] CMD_LONG    = 3'd7;

    // Header byte that ends the stream.
    localparam logic [7:0] TERMINATOR  = 8'hff;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic        put;       // append one byte
        logic        put_hist;  // byte comes from the history read register
        logic [7:0]  put_val;   // constant byte when not from history
        logic        flip;      // bit-reverse the history byte
        logic        rd_start;  // issue a read at rd_addr
        logic        flush;     // emit the packed word
        logic        last;      // flush is the last result of the item
        logic        term;      // emit the terminator result
        logic        clr_pos;   // reset write position
    } dp_cmd_t;

    function automatic logic [7:0] bit_rev(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7-i];
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- rtl/lz3_datapath.sv -----
// Datapath of the LZ3 decompressor: history memory, write position, packing
// register and output register. Depends on lz3_pkg.
`default_nettype none
`include "lz3_command_decompressor_assert.svh"
module lz3_datapath #(
    parameter int AW = 16
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  lz3_pkg::dp_cmd_t     cmd,
    input  wire logic [AW-1:0]   rd_addr,
    output logic [AW-1:0]        wr_pos,
    output logic                 out_full,
    output logic                 clear_busy,
    output logic [127:0]         m_data,
    output logic [4:0]           m_byte_count,
    output logic                 m_last_of_run,
    output logic                 m_stream_end,
    output logic                 m_valid,
    input  wire logic            m_ready
);
    localparam int DEPTH = 1 << AW;
    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic [AW-1:0] pos_reg, pos_next;
    logic [AW:0]   clr_reg;
    logic [127:0]  pack_reg;
    logic [4:0]    cnt_reg;
    logic [7:0]    byte_v;
    logic          ov_reg;

    assign clear_busy = !clr_reg[AW];
    assign byte_v = cmd.put_hist ? (cmd.flip ? lz3_pkg::bit_rev(rd_data_reg) : rd_data_reg)
                                 : cmd.put_val;
    assign pos_next = cmd.clr_pos ? '0 : (cmd.put ? pos_reg + 1'b1 : pos_reg);
    assign wr_pos = pos_reg;

    // Memory: the clearing pass after reset owns the write port.
    always_ff @(posedge aclk) begin
        if (clear_busy) begin
            mem[clr_reg[AW-1:0]] <= 8'h00;
        end else if (cmd.put) begin
            mem[pos_reg] <= byte_v;
        end
        if (cmd.rd_start) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
            pos_reg <= '0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            if (clear_busy) clr_reg <= clr_reg + 1'b1;
            pos_reg <= pos_next;
            if (cmd.flush || cmd.term) begin
                ov_reg  <= 1'b1;
                cnt_reg <= '0;
            end else begin
                if (m_valid && m_ready) ov_reg <= 1'b0;
                if (cmd.put) cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.put) pack_reg[cnt_reg[3:0]*8 +: 8] <= byte_v;
        if (cmd.flush || cmd.term) begin
            for (int i = 0; i < 16; i++) begin
                m_data[i*8 +: 8] <= (5'(i) < cnt_reg && cmd.flush) ? pack_reg[i*8 +: 8] : 8'h00;
            end
            m_byte_count  <= cmd.flush ? cnt_reg : 5'd0;
            m_last_of_run <= cmd.last || cmd.term;
            m_stream_end  <= cmd.term;
        end
    end
    assign m_valid  = ov_reg;
    assign out_full = cnt_reg == 5'd16;

    `LZ3_ASSERT_IMP(a_no_put_full, aclk, aresetn, cmd.put, cnt_reg < 5'd16)
    `LZ3_ASSERT_IMP(a_no_flush_busy, aclk, aresetn, cmd.flush || cmd.term, !ov_reg || m_ready)
    `LZ3_ASSERT_NEXT(a_flush_valid, aclk, aresetn, cmd.flush, m_valid && m_byte_count != 5'd0)
endmodule
`default_nettype wire

// ----- rtl/lz3_controller.sv -----
// Controller of the LZ3 decompressor: parses headers and parameters and
// sequences each run into datapath commands. Depends on lz3_pkg.
`default_nettype none
`include "lz3_command_decompressor_assert.svh"
module lz3_controller #(
    parameter int AW = 16
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire logic [7:0]    s_in_byte,
    input  wire logic [AW-1:0] wr_pos,
    input  wire logic          out_full,
    input  wire logic          clear_busy,
    input  wire logic          m_valid,
    input  wire logic          m_ready,
    output lz3_pkg::dp_cmd_t   cmd,
    output logic [AW-1:0]      rd_addr
);
    typedef enum logic [4:0] {
        ST_PARSE = 5'b00001,
        ST_FILL  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_FLUSH = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [2:0]    phase_reg, phase_next, pcmd_reg, pcmd_next;
    logic [10:0]   len_reg, len_next;
    logic [7:0]    p1_reg, p1_next, p2_reg, p2_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic          alt_reg, alt_next;
    logic          out_free, acc;
    logic [2:0]    hcmd;
    logic [10:0]   hlen;

    assign out_free = !m_valid || m_ready;
    assign s_ready  = state_reg == ST_PARSE && !clear_busy && out_free && !out_full;
    assign acc      = s_valid && s_ready;
    assign rd_addr  = rd_reg;

    always_comb begin
        state_next = state_reg; phase_next = phase_reg; pcmd_next = pcmd_reg;
        len_next = len_reg; p1_next = p1_reg; p2_next = p2_reg; rd_next = rd_reg;
        alt_next = alt_reg;
        cmd = '0;
        hcmd = s_in_byte[7:5];
        hlen = {6'd0, s_in_byte[4:0]} + 11'd1;
        if (phase_reg == lz3_pkg::PH_LONGLEN) begin
            hcmd = pcmd_reg;
            hlen = {len_reg[9:8], s_in_byte} + 11'd1;
        end
        unique case (state_reg)
            ST_PARSE: begin
                if (acc) begin
                    unique case (phase_reg)
                        lz3_pkg::PH_HEADER, lz3_pkg::PH_LONGLEN: begin
                            if (phase_reg == lz3_pkg::PH_HEADER
                                && s_in_byte == lz3_pkg::TERMINATOR) begin
                                cmd.term = 1'b1; cmd.clr_pos = 1'b1;
                            end else if (phase_reg == lz3_pkg::PH_HEADER
                                         && s_in_byte[7:5] == lz3_pkg::CMD_LONG) begin
                                pcmd_next = s_in_byte[4:2];
                                len_next = {1'b0, s_in_byte[1:0], 8'd0};
                                phase_next = lz3_pkg::PH_LONGLEN;
                            end else begin
                                pcmd_next = hcmd; len_next = hlen;
                                priority case (hcmd)
                                    lz3_pkg::CMD_LITERAL: phase_next = lz3_pkg::PH_LIT;
                                    lz3_pkg::CMD_ITERATE: phase_next = lz3_pkg::PH_ITER;
                                    lz3_pkg::CMD_ALTERN:  phase_next = lz3_pkg::PH_ALT1;
                                    lz3_pkg::CMD_ZERO: begin
                                        p1_next = 8'h00; p2_next = 8'h00; alt_next = 1'b0;
                                        phase_next = lz3_pkg::PH_HEADER;
                                        state_next = ST_FILL;
                                    end
                                    default: phase_next = lz3_pkg::PH_OFF1;
                                endcase
                            end
                        end
                        lz3_pkg::PH_OFF1: begin
                            if (s_in_byte[7]) begin
                                rd_next = wr_pos - AW'({s_in_byte[6:0]}) - 1'b1;
                                phase_next = lz3_pkg::PH_HEADER;
                                state_next = ST_READ;
                            end else begin
                                p1_next = s_in_byte; phase_next = lz3_pkg::PH_OFF2;
                            end
                        end
                        lz3_pkg::PH_OFF2: begin
                            rd_next = AW'({p1_reg[6:0], s_in_byte});
                            phase_next = lz3_pkg::PH_HEADER;
                            state_next = ST_READ;
                        end
                        lz3_pkg::PH_ITER: begin
                            p1_next = s_in_byte; p2_next = s_in_byte; alt_next = 1'b0;
                            phase_next = lz3_pkg::PH_HEADER; state_next = ST_FILL;
                        end
                        lz3_pkg::PH_ALT1: begin
                            p1_next = s_in_byte; phase_next = lz3_pkg::PH_ALT2;
                        end
                        lz3_pkg::PH_ALT2: begin
                            p2_next = s_in_byte; alt_next = 1'b0;
                            phase_next = lz3_pkg::PH_HEADER; state_next = ST_FILL;
                        end
                        default: begin
                            cmd.put = 1'b1; cmd.put_val = s_in_byte;
                            len_next = len_reg - 1'b1;
                            if (len_reg <= 11'd1) phase_next = lz3_pkg::PH_HEADER;
                            state_next = ST_FLUSH;
                        end
                    endcase
                end
            end
            ST_FILL: begin
                if (!out_full) begin
                    cmd.put = 1'b1; cmd.put_val = alt_reg ? p2_reg : p1_reg;
                    alt_next = !alt_reg; len_next = len_reg - 1'b1;
                    if (len_reg == 11'd1) state_next = ST_FLUSH;
                end else if (out_free) begin
                    cmd.flush = 1'b1;
                end
            end
            ST_READ: begin
                cmd.rd_start = 1'b1; state_next = ST_COPY;
            end
            ST_COPY: begin
                if (!out_full) begin
                    cmd.put = 1'b1; cmd.put_hist = 1'b1;
                    cmd.flip = pcmd_reg == lz3_pkg::CMD_FLIP;
                    rd_next = pcmd_reg == lz3_pkg::CMD_REVERSE ? rd_reg - 1'b1 : rd_reg + 1'b1;
                    len_next = len_reg - 1'b1;
                    state_next = len_reg == 11'd1 ? ST_FLUSH : ST_READ;
                end else if (out_free) begin
                    cmd.flush = 1'b1;
                end
            end
            default: begin
                if (out_free) begin
                    cmd.flush = 1'b1; cmd.last = 1'b1; state_next = ST_PARSE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_PARSE; phase_reg <= lz3_pkg::PH_HEADER; pcmd_reg <= '0;
            len_reg <= '0; alt_reg <= 1'b0;
        end else begin
            state_reg <= state_next; phase_reg <= phase_next; pcmd_reg <= pcmd_next;
            len_reg <= len_next; alt_reg <= alt_next;
        end
    end
    always_ff @(posedge aclk) begin
        p1_reg <= p1_next; p2_reg <= p2_next; rd_reg <= rd_next;
    end

    `LZ3_ASSERT_IMP(a_ready_parse, aclk, aresetn, s_ready, state_reg == ST_PARSE)
    `LZ3_ASSERT_NEXT(a_read_copy, aclk, aresetn, state_reg == ST_READ, state_reg == ST_COPY)
    `LZ3_ASSERT_IMP(a_len_run, aclk, aresetn,
        state_reg == ST_FILL || state_reg == ST_COPY, len_reg != 11'd0)
endmodule
`default_nettype wire

// ----- rtl/lz3_command_decompressor.sv -----
// Top level of the LZ3 decompressor: joins controller and datapath.
// Depends on lz3_pkg, lz3_controller and lz3_datapath.
`default_nettype none
// LZ3 stream decompressor. Each input transfer carries one compressed byte;
// decoded bytes leave packed up to sixteen per output transfer, with
// last_of_run set on the final transfer that a byte causes and stream_end on
// the single empty transfer caused by a 0xff terminator header. A literal
// byte is written when accepted and then flushed. Fill runs (iterate,
// alternate, zero) produce one byte per cycle unless the packing register is
// full, in which case it is flushed once the output is free. Copy runs
// alternate a read and a copy per byte, since the single history memory read
// port has registered read data. After reset the history memory is zeroed by
// a clearing pass over every address, during which no input is accepted.
// HISTORY_BYTES must be a power of two from 256 to 65536.
module lz3_command_decompressor #(
    parameter int HISTORY_BYTES = 65536
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_out_bytes_low,
    output logic [63:0]      m_out_bytes_high,
    output logic [4:0]       m_byte_count,
    output logic             m_last_of_run,
    output logic             m_stream_end
);
    localparam int AW = $clog2(HISTORY_BYTES);

    lz3_pkg::dp_cmd_t cmd;
    logic [AW-1:0]    rd_addr, wr_pos;
    logic             out_full, clear_busy;
    logic [127:0]     data;

    lz3_controller #(.AW(AW)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
        .s_in_byte(s_in_byte), .wr_pos(wr_pos), .out_full(out_full),
        .clear_busy(clear_busy), .m_valid(m_valid), .m_ready(m_ready),
        .cmd(cmd), .rd_addr(rd_addr)
    );

    lz3_datapath #(.AW(AW)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .rd_addr(rd_addr),
        .wr_pos(wr_pos), .out_full(out_full), .clear_busy(clear_busy),
        .m_data(data), .m_byte_count(m_byte_count), .m_last_of_run(m_last_of_run),
        .m_stream_end(m_stream_end), .m_valid(m_valid), .m_ready(m_ready)
    );

    assign m_out_bytes_low  = data[63:0];
    assign m_out_bytes_high = data[127:64];
endmodule
`default_nettype wire

// ----- dv/tb_lz3_command_decompressor.sv -----
// Self-checking testbench for the LZ3 command decompressor.
// Depends on lz3_pkg and lz3_command_decompressor; needs no files or arguments.
`default_nettype none
module tb_lz3_command_decompressor;
    localparam int         DRAIN_CYCLES = 2200;

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0]  cnt;
        logic        last;
        logic        ends;
    } decoded_word_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_in_byte = 8'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_out_bytes_low;
    logic [63:0] m_out_bytes_high;
    logic [4:0]  m_byte_count;
    logic        m_last_of_run;
    logic        m_stream_end;

    lz3_command_decompressor dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_in_byte(s_in_byte),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_out_bytes_low(m_out_bytes_low), .m_out_bytes_high(m_out_bytes_high),
        .m_byte_count(m_byte_count), .m_last_of_run(m_last_of_run),
        .m_stream_end(m_stream_end)
    );

    always #6 aclk = ~aclk;

    // Stream bytes waiting to be driven, and decoded words waiting to arrive.
    logic [7:0]    stream_bytes[$];
    decoded_word_t pending_words[$];
    int            total_bytes = 0;
    int            sent_bytes = 0;
    int            words_seen = 0;
    int            ends_seen = 0;
    int            mismatches = 0;
    bit            stim_done = 1'b0;
    bit            took = 1'b0;

    // Shadow decoder state.
    logic [7:0]  hist[65536];
    logic [2:0]  phase_sh = lz3_pkg::PH_HEADER;
    logic [2:0]  cmd_sh = lz3_pkg::CMD_LITERAL;
    logic [10:0] len_sh = 11'd0;
    logic [7:0]  param_sh = 8'd0;
    logic [15:0] wpos = 16'd0;
    logic [7:0]  produced[$];

    initial begin
        for (int i = 0; i < 65536; i++) hist[i] = 8'd0;
    end

    function automatic logic [7:0] reverse_bits(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) r[i] = v[7 - i];
        return r;
    endfunction

    function automatic void emit(input logic [7:0] b);
        hist[wpos] = b;
        wpos = wpos + 16'd1;
        produced.push_back(b);
    endfunction

    function automatic void copy_run(input logic [15:0] src);
        logic [15:0] rd;
        logic [7:0]  b;
        rd = src;
        for (int n = 0; n < len_sh; n++) begin
            b = hist[rd];
            if (cmd_sh == lz3_pkg::CMD_FLIP) b = reverse_bits(b);
            emit(b);
            rd = (cmd_sh == lz3_pkg::CMD_REVERSE) ? rd - 16'd1 : rd + 16'd1;
        end
        len_sh = 11'd0;
        phase_sh = lz3_pkg::PH_HEADER;
    endfunction

    function automatic void begin_command();
        case (cmd_sh)
            lz3_pkg::CMD_LITERAL: phase_sh = lz3_pkg::PH_LIT;
            lz3_pkg::CMD_ITERATE: phase_sh = lz3_pkg::PH_ITER;
            lz3_pkg::CMD_ALTERN:  phase_sh = lz3_pkg::PH_ALT1;
            lz3_pkg::CMD_ZERO: begin
                for (int n = 0; n < len_sh; n++) emit(8'd0);
                len_sh = 11'd0;
                phase_sh = lz3_pkg::PH_HEADER;
            end
            default: phase_sh = lz3_pkg::PH_OFF1;
        endcase
    endfunction

    // Decode one accepted stream byte and queue the words it must produce.
    function automatic void decode_byte(input logic [7:0] b);
        decoded_word_t w;
        int            cnt;
        bit            ended;
        ended = 1'b0;
        produced.delete();
        case (phase_sh)
            lz3_pkg::PH_HEADER: begin
                if (b == lz3_pkg::TERMINATOR) begin
                    wpos = 16'd0;
                    ended = 1'b1;
                end else if (b[7:5] == lz3_pkg::CMD_LONG) begin
                    cmd_sh = b[4:2];
                    len_sh = {1'b0, b[1:0], 8'd0};
                    phase_sh = lz3_pkg::PH_LONGLEN;
                end else begin
                    cmd_sh = b[7:5];
                    len_sh = {6'd0, b[4:0]} + 11'd1;
                    begin_command();
                end
            end
            lz3_pkg::PH_LONGLEN: begin
                len_sh = {1'b0, len_sh[9:8], 8'd0} + {3'd0, b} + 11'd1;
                begin_command();
            end
            lz3_pkg::PH_OFF1: begin
                if (b[7]) copy_run(wpos - {9'd0, b[6:0]} - 16'd1);
                else begin
                    param_sh = b;
                    phase_sh = lz3_pkg::PH_OFF2;
                end
            end
            lz3_pkg::PH_OFF2: copy_run({1'b0, param_sh[6:0], b});
            lz3_pkg::PH_ITER: begin
                for (int n = 0; n < len_sh; n++) emit(b);
                len_sh = 11'd0;
                phase_sh = lz3_pkg::PH_HEADER;
            end
            lz3_pkg::PH_ALT1: begin
                param_sh = b;
                phase_sh = lz3_pkg::PH_ALT2;
            end
            lz3_pkg::PH_ALT2: begin
                for (int n = 0; n < len_sh; n++) emit(n[0] ? b : param_sh);
                len_sh = 11'd0;
                phase_sh = lz3_pkg::PH_HEADER;
            end
            default: begin
                emit(b);
                if (len_sh != 0) len_sh = len_sh - 11'd1;
                if (len_sh == 0) phase_sh = lz3_pkg::PH_HEADER;
            end
        endcase
        if (ended) begin
            w.lo = '0; w.hi = '0; w.cnt = 5'd0; w.last = 1'b1; w.ends = 1'b1;
            pending_words.push_back(w);
        end
        while (produced.size() > 0) begin
            w.lo = '0; w.hi = '0; w.ends = 1'b0;
            cnt = (produced.size() > 16) ? 16 : produced.size();
            for (int i = 0; i < cnt; i++) begin
                if (i < 8) w.lo[8*i +: 8] = produced.pop_front();
                else       w.hi[8*(i-8) +: 8] = produced.pop_front();
            end
            w.cnt = cnt[4:0];
            w.last = (produced.size() == 0);
            pending_words.push_back(w);
        end
    endfunction

    // Append one well-formed command with random content.
    function automatic void add_command();
        logic [2:0] cmd;
        int         len;
        bit         long_form;
        cmd = 3'($urandom_range(0, 7));
        long_form = (cmd == lz3_pkg::CMD_LONG) || ($urandom_range(0, 9) == 0);
        if (cmd == lz3_pkg::CMD_LONG) cmd = 3'($urandom_range(0, 7));
        len = long_form ? (($urandom_range(0, 7) == 0) ? $urandom_range(1, 1024)
                                                       : $urandom_range(1, 64))
                        : $urandom_range(1, 32);
        // A long header of inner command 7 with top length bits 3 would read as the end.
        if (long_form && cmd == lz3_pkg::CMD_LONG && len > 768) len = len - 512;
        if (cmd == lz3_pkg::CMD_LITERAL && len > 40) len = $urandom_range(1, 40);
        if (long_form) begin
            stream_bytes.push_back({lz3_pkg::CMD_LONG, cmd, 2'((len - 1) >> 8)});
            stream_bytes.push_back(8'(len - 1));
        end else begin
            stream_bytes.push_back({cmd, 5'(len - 1)});
        end
        case (cmd)
            lz3_pkg::CMD_LITERAL:
                for (int i = 0; i < len; i++) stream_bytes.push_back(8'($urandom));
            lz3_pkg::CMD_ITERATE: stream_bytes.push_back(8'($urandom));
            lz3_pkg::CMD_ALTERN: begin
                stream_bytes.push_back(8'($urandom));
                stream_bytes.push_back(8'($urandom));
            end
            lz3_pkg::CMD_ZERO: ;
            default: begin
                if ($urandom_range(0, 1)) stream_bytes.push_back(8'h80 | 8'($urandom));
                else begin
                    stream_bytes.push_back(8'($urandom) & 8'h7f);
                    stream_bytes.push_back(8'($urandom));
                end
            end
        endcase
    endfunction

    // Directed opening, then random commands with some noise and terminators.
    initial begin
        stream_bytes = '{
            8'h00, 8'h00,                 // one literal zero
            8'h01, 8'hff, 8'h5a,          // literal 0xff taken as data
            8'h3f, 8'hff,                 // iterate 0xff, 32 times
            8'h43, 8'haa, 8'h55,          // alternate pair
            8'h62,                        // three zeros
            8'hef, 8'hff,                 // long zero run of 1024
            8'h87, 8'hff,                 // repeat 8 bytes from 128 back
            8'ha3, 8'h00, 8'h01,          // bit-reversed repeat from address 1
            8'hc4, 8'h00, 8'h00,          // reverse repeat wrapping below zero
            8'hfc, 8'h02, 8'h80,          // long form, inner command 7 acts as repeat
            lz3_pkg::TERMINATOR
        };
        while (stream_bytes.size() < 480) begin
            case ($urandom_range(0, 19))
                0:       stream_bytes.push_back(8'($urandom));
                1:       stream_bytes.push_back(lz3_pkg::TERMINATOR);
                default: add_command();
            endcase
        end
        stream_bytes.push_back(lz3_pkg::TERMINATOR);
        total_bytes = stream_bytes.size();
        stim_done = 1'b1;
    end

    // Idle behavior by quarter of the stream: none, sender, receiver, both.
    function automatic bit idle_now(input bit sender_side);
        int quarter;
        quarter = (sent_bytes * 4) / ((total_bytes == 0) ? 1 : total_bytes);
        case (quarter)
            0: return 1'b0;
            1: return sender_side && ($urandom_range(0, 99) < 75);
            2: return !sender_side && ($urandom_range(0, 99) < 75);
            default: return $urandom_range(0, 99) < 10;
        endcase
    endfunction

    // Driver: updates on the falling edge so the DUT sees stable inputs.
    always @(negedge aclk) begin
        if (aresetn && stim_done) begin
            if (!s_valid || took) begin
                if (stream_bytes.size() > 0 && !idle_now(1'b1)) begin
                    s_valid <= 1'b1;
                    s_in_byte <= stream_bytes.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
            m_ready <= !idle_now(1'b0);
        end
    end

    // Monitor: predicts on each input transfer, checks each output transfer.
    always @(posedge aclk) begin
        decoded_word_t w;
        took = 1'b0;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                took = 1'b1;
                sent_bytes++;
                decode_byte(s_in_byte);
            end
            if (m_valid && m_ready) begin
                words_seen++;
                if (pending_words.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output transfer: count %0d", m_byte_count);
                end else begin
                    w = pending_words.pop_front();
                    if (w.ends) ends_seen++;
                    if (m_out_bytes_low !== w.lo || m_out_bytes_high !== w.hi ||
                        m_byte_count !== w.cnt || m_last_of_run !== w.last ||
                        m_stream_end !== w.ends) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch at word %0d: exp %h_%h n%0d l%b e%b got %h_%h n%0d l%b e%b",
                                     words_seen, w.hi, w.lo, w.cnt, w.last, w.ends,
                                     m_out_bytes_high, m_out_bytes_low, m_byte_count,
                                     m_last_of_run, m_stream_end);
                    end
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        wait (stim_done);
        while (stream_bytes.size() > 0 || s_valid || pending_words.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d stream bytes under four idle patterns; checked %0d words, %0d stream ends.",
                 sent_bytes, words_seen, ends_seen);
        if (mismatches == 0 && pending_words.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d words never arrived", mismatches, pending_words.size());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog sized for the clearing pass plus long copy runs under heavy stalls.
    initial begin
        #48_000_000;
        $display("timeout with %0d words outstanding", pending_words.size());
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
+incdir+rtl
rtl/lz3_pkg.sv
rtl/lz3_datapath.sv
rtl/lz3_controller.sv
rtl/lz3_command_decompressor.sv
dv/tb_lz3_command_decompressor.sv
